### sv/mhcc_pkg.sv
// Package for the multiplicative hash collision checker.
// Holds the word types, field widths, state codes and outcome codes.
// No dependencies; the checker and its testbench import it.
package mhcc_pkg;

   localparam int KEY_BITS            = 64;
   localparam int VALUE_BITS          = 64;
   localparam int SLOT_BITS           = 12;
   localparam int INDEX_W             = 4;
   localparam int INDEX_BITS_MIN      = 1;
   localparam int INDEX_BITS_MAX      = 12;
   localparam int INDEX_BITS_RESET    = 12;
   localparam int EPOCH_BITS          = 8;
   localparam int CSR_DATA_BITS       = 64;
   localparam int TABLE_DEPTH_DEFAULT = 4096;

   typedef enum logic [1:0] {
      OUTCOME_STORED  = 2'd0,
      OUTCOME_MATCH   = 2'd1,
      OUTCOME_COLLIDE = 2'd2,
      OUTCOME_CLEARED = 2'd3
   } outcome_type;

   typedef enum logic {
      CMD_CLEAR = 1'b0,
      CMD_TEST  = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_MULTIPLIER = 1'b0,
      CSR_INDEX_BITS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
   } req_word_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]    slot;
      outcome_type             outcome;
      logic                    failed;
   } rsp_word_type;

endpackage

### sv/mhcc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the slot table of the collision checker; no package dependency.
module mhcc_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 4096
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/multiplicative_hash_collision_check.sv
// A request is hashed, read and checked in turn; the result word is shown for one cycle.
// A new start is taken in the result cycle, unless it is a clear that wraps the epoch.
// The work is split across the 64-bit multiply, the slot reduction and the RAM read.
// Reset: a sweep marks every slot empty, with busy held high; every 255th clear
// triggers the same sweep.
module multiplicative_hash_collision_check #(
   parameter int TABLE_DEPTH = mhcc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mhcc_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   output mhcc_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_write_en,
   input  mhcc_pkg::csr_index_type             csr_index,
   input  logic [mhcc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import mhcc_pkg::*;

   localparam int ADDR_W    = $clog2(TABLE_DEPTH);
   localparam int HALF      = KEY_BITS / 2;
   localparam int QUOT_BITS = (SLOT_BITS > ADDR_W - 1) ? SLOT_BITS - ADDR_W + 1 : 1;
   localparam int REM_W     = ((SLOT_BITS > ADDR_W) ? SLOT_BITS : ADDR_W) + 1;
   localparam int WORD_W    = EPOCH_BITS + VALUE_BITS;

   state_type                state_ff, state_in;
   logic [VALUE_BITS-1:0]    mult_ff, mult_in;
   logic [INDEX_W-1:0]       ibits_ff, ibits_in;
   logic [EPOCH_BITS-1:0]    epoch_ff, epoch_in;
   logic                     failed_ff, failed_in;
   logic [ADDR_W-1:0]        sweep_ff, sweep_in;

   cmd_type                  cmd_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   logic [KEY_BITS-1:0]      ll_ff, ll_in;
   logic [HALF-1:0]          lh_ff, lh_in;
   logic [HALF-1:0]          hl_ff, hl_in;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in;
   logic [ADDR_W-1:0]        addr_ff;

   logic                     accept;
   logic                     wrap;
   logic [HALF-1:0]          top_sum;
   logic [INDEX_W-1:0]       ibits_sat;
   logic [REM_W-1:0]         rem;
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [WORD_W-1:0]        ram_wr_data;
   logic [WORD_W-1:0]        ram_rd_data;
   logic [EPOCH_BITS-1:0]    rd_epoch;
   logic [VALUE_BITS-1:0]    rd_value;

   assign wrap   = (state_ff == ST_CHECK) && (cmd_ff == CMD_CLEAR) && (&epoch_ff);
   assign busy   = !((state_ff == ST_IDLE) || ((state_ff == ST_CHECK) && !wrap));
   assign accept = start && !busy;

   assign ll_in = req_word.key[HALF-1:0] * mult_ff[HALF-1:0];
   assign lh_in = req_word.key[HALF-1:0] * mult_ff[KEY_BITS-1:HALF];
   assign hl_in = req_word.key[KEY_BITS-1:HALF] * mult_ff[HALF-1:0];

   assign top_sum = ll_ff[KEY_BITS-1:HALF] + lh_ff + hl_ff;

   always_comb begin
      if (ibits_ff < INDEX_W'(INDEX_BITS_MIN)) begin
         ibits_sat = INDEX_W'(INDEX_BITS_MIN);
      end else if (ibits_ff > INDEX_W'(INDEX_BITS_MAX)) begin
         ibits_sat = INDEX_W'(INDEX_BITS_MAX);
      end else begin
         ibits_sat = ibits_ff;
      end
   end

   assign slot_in = top_sum[HALF-1 -: SLOT_BITS] >> (INDEX_W'(SLOT_BITS) - ibits_sat);

   // The slot is reduced modulo the table depth by restoring subtraction.
   always_comb begin
      rem = REM_W'(slot_ff);
      for (int k = QUOT_BITS - 1; k >= 0; k--) begin
         if (rem >= (REM_W'(TABLE_DEPTH) << k)) begin
            rem = rem - (REM_W'(TABLE_DEPTH) << k);
         end
      end
   end

   always_comb begin
      mult_in  = mult_ff;
      ibits_in = ibits_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MULTIPLIER: mult_in  = csr_data[VALUE_BITS-1:0];
            CSR_INDEX_BITS: ibits_in = csr_data[INDEX_W-1:0];
            default:        mult_in  = mult_ff;
         endcase
      end
   end

   assign rd_epoch = ram_rd_data[WORD_W-1:VALUE_BITS];
   assign rd_value = ram_rd_data[VALUE_BITS-1:0];

   always_comb begin
      state_in         = state_ff;
      epoch_in         = epoch_ff;
      failed_in        = failed_ff;
      sweep_in         = sweep_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = addr_ff;
      ram_wr_data      = {epoch_ff, value_ff};
      rsp_valid        = 1'b0;
      rsp_word.slot    = slot_ff;
      rsp_word.outcome = OUTCOME_STORED;
      rsp_word.failed  = failed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rsp_valid = 1'b1;
            if (cmd_ff == CMD_CLEAR) begin
               failed_in        = 1'b0;
               rsp_word.slot    = '0;
               rsp_word.outcome = OUTCOME_CLEARED;
               if (wrap) begin
                  epoch_in = EPOCH_BITS'(1);
                  sweep_in = '0;
               end else begin
                  epoch_in = epoch_ff + EPOCH_BITS'(1);
               end
            end else if ((rd_epoch == epoch_ff) && (rd_value != '0)) begin
               if (rd_value == value_ff) begin
                  rsp_word.outcome = OUTCOME_MATCH;
               end else begin
                  rsp_word.outcome = OUTCOME_COLLIDE;
                  failed_in        = 1'b1;
               end
            end else begin
               ram_wr_en = 1'b1;
            end
            rsp_word.failed = failed_in;
            if (wrap) begin
               state_in = ST_SWEEP;
            end else if (accept) begin
               state_in = ST_HASH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         mult_ff   <= '0;
         ibits_ff  <= INDEX_W'(INDEX_BITS_RESET);
         epoch_ff  <= EPOCH_BITS'(1);
         failed_ff <= 1'b0;
         sweep_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         mult_ff   <= mult_in;
         ibits_ff  <= ibits_in;
         epoch_ff  <= epoch_in;
         failed_ff <= failed_in;
         sweep_ff  <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_word.cmd;
         value_ff <= req_word.value;
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
      end
      if (state_ff == ST_HASH) begin
         slot_ff <= slot_in;
      end
      if (state_ff == ST_READ) begin
         addr_ff <= rem[ADDR_W-1:0];
      end
   end

   mhcc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rem[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("accepted word did not produce a result three cycles later");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !ram_wr_en)
      else $error("table written while a lookup read is in flight");

   a_failed_rises_on_collision: assert property (@(posedge clock) disable iff (reset)
      $rose(failed_ff) |-> $past(rsp_valid && (rsp_word.outcome == OUTCOME_COLLIDE)))
      else $error("failure flag set without a collision");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("current epoch matches the swept tag value");

endmodule

### sim/multiplicative_hash_collision_check_test.sv
// Self-checking testbench for the multiplicative hash collision checker.
// A scoreboard class predicts slot, outcome and sticky flag for each word.
// Depends on mhcc_pkg and multiplicative_hash_collision_check.
`timescale 1ns / 100ps

module multiplicative_hash_collision_check_test;
   import mhcc_pkg::*;

   class slot_table_tracker;
      logic [63:0]          multiplier;
      logic [INDEX_W-1:0]   index_bits;
      logic [63:0]          held_value [TABLE_DEPTH_DEFAULT];
      bit                   occupied [TABLE_DEPTH_DEFAULT];
      bit                   sticky_fail;
      rsp_word_type         expected_words [$];
      int                   errors;

      function new();
         multiplier = '0;
         index_bits = INDEX_W'(INDEX_BITS_RESET);
         foreach (occupied[i]) occupied[i] = 1'b0;
         sticky_fail = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [63:0] data);
         if (idx == CSR_MULTIPLIER) multiplier = data;
         else index_bits = data[INDEX_W-1:0];
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_word(req_word_type w);
         rsp_word_type          r;
         int                    width;
         logic [63:0]           product;
         logic [SLOT_BITS-1:0]  s;
         if (w.cmd == CMD_CLEAR) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            sticky_fail = 1'b0;
            r.slot = '0;
            r.outcome = OUTCOME_CLEARED;
         end else begin
            width = index_bits;
            if (width < INDEX_BITS_MIN) width = INDEX_BITS_MIN;
            if (width > INDEX_BITS_MAX) width = INDEX_BITS_MAX;
            product = w.key * multiplier;
            s = SLOT_BITS'(product >> (64 - width));
            r.slot = s;
            if (!occupied[s] || held_value[s] == 64'd0) begin
               held_value[s] = w.value;
               occupied[s] = 1'b1;
               r.outcome = OUTCOME_STORED;
            end else if (held_value[s] == w.value) begin
               r.outcome = OUTCOME_MATCH;
            end else begin
               sticky_fail = 1'b1;
               r.outcome = OUTCOME_COLLIDE;
            end
         end
         r.failed = sticky_fail;
         expected_words.push_back(r);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word %0h arrived with nothing expected", got);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got.slot !== want.slot) begin
            $error("slot: expected %0h, got %0h", want.slot, got.slot);
            errors++;
         end
         if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
            errors++;
         end
         if (got.failed !== want.failed) begin
            $error("failed: expected %0b, got %0b", want.failed, got.failed);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_word_type              req_word = '0;
   logic                      rsp_valid;
   rsp_word_type              rsp_word;
   logic                      csr_write_en = 1'b0;
   csr_index_type             csr_index = CSR_MULTIPLIER;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   slot_table_tracker         tracker = new();
   logic [63:0]               key_pool [$];
   logic [63:0]               value_pool [4];
   bit                        burst = 1'b0;

   multiplicative_hash_collision_check DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) tracker.check_word(rsp_word);
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_word_type make_word(cmd_type c, logic [63:0] k, logic [63:0] v);
      req_word_type w;
      w.cmd = c;
      w.key = k;
      w.value = v;
      return w;
   endfunction

   function automatic int draw_gap();
      if ($urandom_range(0, 29) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic send(req_word_type w, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.note_word(w);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic configure(logic [63:0] mult, logic [INDEX_W-1:0] width);
      logic [63:0] width_data;
      width_data = (rand64() & ~64'hF) | 64'(width);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MULTIPLIER;
      csr_data <= mult;
      @(posedge clock);
      tracker.write_reg(CSR_MULTIPLIER, mult);
      csr_index <= CSR_INDEX_BITS;
      csr_data <= width_data;
      @(posedge clock);
      tracker.write_reg(CSR_INDEX_BITS, width_data);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_phase(int count, int clear_pct, bit hold_mid);
      logic [63:0] k;
      logic [63:0] v;
      cmd_type     c;
      for (int i = 0; i < count; i++) begin
         if (hold_mid && i == count / 2) settle();
         c = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_TEST;
         if (key_pool.size() > 0 && $urandom_range(0, 1) == 1) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else begin
            k = rand64();
            key_pool.push_back(k);
            if (key_pool.size() > 24) void'(key_pool.pop_front());
         end
         v = ($urandom_range(0, 4) == 0) ? rand64() : value_pool[$urandom_range(0, 3)];
         send(make_word(c, k, v), draw_gap());
      end
   endtask

   initial begin
      logic [63:0]         phase_mult [10];
      logic [INDEX_W-1:0]  phase_width [10];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      // Directed: zero value as empty, match, collision, sticky flag, clear.
      configure(64'd1, 4'd12);
      send(make_word(CMD_CLEAR, rand64(), rand64()), 0);
      send(make_word(CMD_TEST, 64'd0, 64'd0), 0);
      send(make_word(CMD_TEST, 64'd0, 64'd5), 0);
      send(make_word(CMD_TEST, 64'd0, 64'd5), 3);
      send(make_word(CMD_TEST, 64'h000F_FFFF_FFFF_FFFF, 64'd6), 0);
      send(make_word(CMD_TEST, '1, '1), 17);
      send(make_word(CMD_TEST, '1, '1), 0);
      send(make_word(CMD_TEST, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000), 1);
      send(make_word(CMD_CLEAR, '1, '1), 0);
      send(make_word(CMD_TEST, 64'd0, 64'd6), 0);
      send(make_word(CMD_TEST, 64'h000F_FFFF_FFFF_FFFF, 64'd6), 0);
      settle();
      // Index width zero saturates to one.
      configure('1, 4'd0);
      send(make_word(CMD_CLEAR, 64'd0, 64'd0), 0);
      send(make_word(CMD_TEST, 64'd1, 64'd7), 0);
      send(make_word(CMD_TEST, 64'd2, 64'd8), 2);
      send(make_word(CMD_TEST, 64'd0, 64'd9), 0);
      send(make_word(CMD_TEST, 64'd0, 64'd9), 0);
      settle();
      // Index widths above twelve saturate to twelve.
      configure(64'h9E37_79B9_7F4A_7C15, 4'd15);
      send(make_word(CMD_TEST, 64'h0123_4567_89AB_CDEF, 64'h55), 0);
      send(make_word(CMD_TEST, 64'h0123_4567_89AB_CDEF, 64'h55), 0);
      send(make_word(CMD_TEST, 64'hFEDC_BA98_7654_3210, 64'h66), 5);
      settle();
      configure(64'd0, 4'd13);
      send(make_word(CMD_TEST, rand64(), 64'h11), 0);
      send(make_word(CMD_TEST, rand64(), 64'h22), 0);
      send(make_word(CMD_CLEAR, rand64(), rand64()), 0);
      settle();

      phase_mult = '{'1, rand64() | 64'd1, 64'd0, rand64(), 64'd1,
                     rand64(), 64'h8000_0000_0000_0000, rand64() | 64'd1, rand64(), '1};
      phase_width = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd4, 4'd13, 4'd8, 4'd2, 4'd12, 4'd6};
      for (int p = 0; p < 10; p++) begin
         configure(phase_mult[p], phase_width[p]);
         value_pool[0] = 64'd0;
         value_pool[1] = 64'($urandom_range(1, 3));
         value_pool[2] = rand64();
         value_pool[3] = rand64();
         key_pool.delete();
         send(make_word(CMD_CLEAR, rand64(), rand64()), draw_gap());
         random_phase(190, (p % 2 == 1) ? 25 : 3, p % 3 == 0);
         settle();
      end

      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
sv/mhcc_pkg.sv
sv/mhcc_ram.sv
sv/multiplicative_hash_collision_check.sv
sim/multiplicative_hash_collision_check_test.sv
